[design/uniform_border_margin_detect_macros.svh]
// Assertion helpers shared by the detector modules.
// Each expects aclk and aresetn in the scope of the module that uses it.
`ifndef UNIFORM_BORDER_MARGIN_DETECT_MACROS_SVH
`define UNIFORM_BORDER_MARGIN_DETECT_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define UBMD_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle.
`define UBMD_ASSERT_NEXT(name, trig, cond, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) \
        else $error(msg);

`endif

[design/ubmd_pkg.sv]
`timescale 1ns / 1ps
package ubmd_pkg;

    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 1;
    localparam int COLOR_W     = 24;
    localparam int MARGIN_W    = 12;
    localparam int RESULT_W    = 4 * MARGIN_W;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

    localparam logic [CFG_W-1:0] RESET_FRAME_WIDTH  = 13'd640;
    localparam logic [CFG_W-1:0] RESET_FRAME_HEIGHT = 13'd480;

    // Raster position tags attached to each pixel by the front end
    typedef struct packed {
        logic col_zero;
        logic row_zero;
        logic row_end;
        logic frame_end;
    } pos_flags_t;

    localparam int FLAGS_W = $bits(pos_flags_t);

endpackage

[design/ubmd_front.sv]
`timescale 1ns / 1ps
`include "uniform_border_margin_detect_macros.svh"
module ubmd_front #(
    parameter int MAX_WIDTH  = ubmd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ubmd_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_clear,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]        w_eff,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]       h_eff,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [ubmd_pkg::COLOR_W-1:0]          s_pixel,
    input  logic                                  q_full,
    output logic                                  push,
    output logic [ubmd_pkg::COLOR_W-1:0]          push_pixel,
    output logic [$clog2(MAX_WIDTH)-1:0]          push_col,
    output logic [$clog2(MAX_HEIGHT)-1:0]         push_row,
    output ubmd_pkg::pos_flags_t                  push_flags
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [WW-1:0] col_inc;
    logic [HW-1:0] row_inc;
    logic          row_end;
    logic          frame_end;

    assign s_tready = !q_full;
    assign push     = s_tvalid && s_tready;

    assign col_inc   = WW'(col_reg) + WW'(1);
    assign row_inc   = HW'(row_reg) + HW'(1);
    assign row_end   = (col_inc >= w_eff);
    assign frame_end = row_end && (row_inc >= h_eff);

    assign push_pixel          = s_pixel;
    assign push_col            = col_reg;
    assign push_row            = row_reg;
    assign push_flags.col_zero  = (col_reg == '0);
    assign push_flags.row_zero  = (row_reg == '0);
    assign push_flags.row_end   = row_end;
    assign push_flags.frame_end = frame_end;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (push) begin
            if (frame_end) begin
                col_next = '0;
                row_next = '0;
            end else if (row_end) begin
                col_next = '0;
                row_next = RW'(row_inc);
            end else begin
                col_next = CW'(col_inc);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_clear) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    `UBMD_ASSERT_ALWAYS(a_col_in_row, WW'(col_reg) < w_eff, "column position beyond frame width")
    `UBMD_ASSERT_ALWAYS(a_row_in_frame, HW'(row_reg) < h_eff, "row position beyond frame height")

endmodule

[design/ubmd_queue.sv]
`timescale 1ns / 1ps
`include "uniform_border_margin_detect_macros.svh"
module ubmd_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = ubmd_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic              full,
    output logic              head_valid,
    output logic [DATA_W-1:0] head_data
);

    localparam int PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QCW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]    count_reg, count_next;

    assign full       = (count_reg == QCW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + QCW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    `UBMD_ASSERT_ALWAYS(a_no_overrun, !(push && full && !pop) && !(pop && !head_valid), "queue overrun or underrun")

endmodule

[design/ubmd_back.sv]
`timescale 1ns / 1ps
`include "uniform_border_margin_detect_macros.svh"
module ubmd_back #(
    parameter int MAX_WIDTH  = ubmd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ubmd_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_clear,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]        w_eff,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]       h_eff,
    input  logic                                  head_valid,
    input  logic [ubmd_pkg::COLOR_W-1:0]          head_pixel,
    input  logic [$clog2(MAX_WIDTH)-1:0]          head_col,
    input  logic [$clog2(MAX_HEIGHT)-1:0]         head_row,
    input  ubmd_pkg::pos_flags_t                  head_flags,
    output logic                                  pop,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [ubmd_pkg::RESULT_W-1:0]         m_tdata
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int CLR_W = ubmd_pkg::COLOR_W;
    localparam int MW = ubmd_pkg::MARGIN_W;

    // frame state: flags and counts are control, colours and extents payload
    logic             left_found_reg, left_found_next;
    logic             top_found_reg, top_found_next;
    logic             right_found_reg, right_found_next;
    logic             row_uni_reg, row_uni_next;
    logic [HW-1:0]    trail_reg, trail_next;
    logic [WW-1:0]    run_reg, run_next;
    logic [CW-1:0]    left_min_reg, left_min_next;
    logic [RW-1:0]    top_row_reg, top_row_next;
    logic [CW-1:0]    right_max_reg, right_max_next;
    logic [CLR_W-1:0] top_left_reg, top_left_next;
    logic [CLR_W-1:0] prev_px_reg;
    logic [CLR_W-1:0] top_right_reg, top_right_next;
    logic [CLR_W-1:0] row_first_reg, row_first_next;
    logic [CLR_W-1:0] trail_color_reg, trail_color_next;

    logic                             m_tvalid_reg;
    logic [ubmd_pkg::RESULT_W-1:0]    m_tdata_reg;

    logic          diff_tl;
    logic [WW-1:0] right_from_run;
    logic [WW-1:0] right_span;
    logic [31:0]   left_out, top_out, right_out, bottom_out;

    assign pop      = head_valid && (!head_flags.frame_end || !m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        top_left_next = (head_flags.col_zero && head_flags.row_zero) ? head_pixel : top_left_reg;
        diff_tl       = (head_pixel != top_left_next);

        // left and top against the frame's first pixel
        left_min_next   = left_min_reg;
        left_found_next = left_found_reg || diff_tl;
        if (diff_tl && (!left_found_reg || head_col < left_min_reg)) begin
            left_min_next = head_col;
        end
        top_row_next   = top_row_reg;
        top_found_next = top_found_reg || diff_tl;
        if (diff_tl && !top_found_reg) begin
            top_row_next = head_row;
        end

        // right: trailing run on row zero, then widest differing column below
        run_next = (head_flags.col_zero || head_pixel != prev_px_reg) ?
                   WW'(1) : run_reg + WW'(1);
        right_from_run   = w_eff - WW'(1) - run_next;
        right_max_next   = right_max_reg;
        right_found_next = right_found_reg;
        top_right_next   = top_right_reg;
        if (head_flags.row_zero) begin
            if (head_flags.row_end) begin
                top_right_next = head_pixel;
                if (run_next < w_eff) begin
                    right_max_next   = CW'(right_from_run);
                    right_found_next = 1'b1;
                end
            end
        end else if (head_pixel != top_right_reg) begin
            if (!right_found_reg || head_col > right_max_reg) begin
                right_max_next   = head_col;
                right_found_next = 1'b1;
            end
        end

        // bottom: run of uniform rows of one colour ending at the last row
        row_first_next = head_flags.col_zero ? head_pixel : row_first_reg;
        row_uni_next   = head_flags.col_zero ? 1'b1 :
                         (row_uni_reg && head_pixel == row_first_reg);
        trail_next       = trail_reg;
        trail_color_next = trail_color_reg;
        if (head_flags.row_end) begin
            if (!row_uni_next) begin
                trail_next = '0;
            end else if (trail_reg != '0 && row_first_next == trail_color_reg) begin
                trail_next = trail_reg + HW'(1);
            end else begin
                trail_next       = HW'(1);
                trail_color_next = row_first_next;
            end
        end

        right_span = w_eff - WW'(1) - WW'(right_max_next);
        left_out   = left_found_next ? 32'(left_min_next) : 32'd0;
        top_out    = top_found_next ? 32'(top_row_next) : 32'd0;
        right_out  = right_found_next ? 32'(right_span) : 32'd0;
        bottom_out = (trail_next < h_eff) ? 32'(trail_next) : 32'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_clear) begin
            left_found_reg  <= 1'b0;
            top_found_reg   <= 1'b0;
            right_found_reg <= 1'b0;
            row_uni_reg     <= 1'b1;
            trail_reg       <= '0;
            run_reg         <= '0;
        end else if (pop) begin
            if (head_flags.frame_end) begin
                left_found_reg  <= 1'b0;
                top_found_reg   <= 1'b0;
                right_found_reg <= 1'b0;
                row_uni_reg     <= 1'b1;
                trail_reg       <= '0;
                run_reg         <= '0;
            end else begin
                left_found_reg  <= left_found_next;
                top_found_reg   <= top_found_next;
                right_found_reg <= right_found_next;
                row_uni_reg     <= row_uni_next;
                trail_reg       <= trail_next;
                run_reg         <= run_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            left_min_reg    <= left_min_next;
            top_row_reg     <= top_row_next;
            right_max_reg   <= right_max_next;
            top_left_reg    <= top_left_next;
            prev_px_reg     <= head_pixel;
            top_right_reg   <= top_right_next;
            row_first_reg   <= row_first_next;
            trail_color_reg <= trail_color_next;
        end
    end

    // hold the result until the sink takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (pop && head_flags.frame_end) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && head_flags.frame_end) begin
            m_tdata_reg <= {bottom_out[MW-1:0], right_out[MW-1:0],
                            top_out[MW-1:0], left_out[MW-1:0]};
        end
    end

    `UBMD_ASSERT_NEXT(a_frame_end_shows_result, pop && head_flags.frame_end, m_tvalid_reg, "frame end did not raise a result")
    `UBMD_ASSERT_NEXT(a_result_not_dropped, m_tvalid_reg && !m_tready, m_tvalid_reg, "pending result lost")

endmodule

[design/uniform_border_margin_detect.sv]
`timescale 1ns / 1ps
// Channel  | Dir | Handshake          | Payload (lowest bit first)
// s_       | in  | s_tvalid/s_tready  | s_tdata: pixel_color[23:0]
// m_       | out | m_tvalid/m_tready  | m_tdata: margin_left, margin_top,
//          |     |                    |          margin_right, margin_bottom
// cfg_     | in  | cfg_we             | cfg_index, cfg_wdata (13 bits)
//
// One pixel per cycle while no result is held back; the front counter and
// the back compare stage have a two-entry queue between them.
// The result is registered when the back end takes the frame's last pixel.
// Reset is synchronous on aresetn; any register write restarts the frame.
// A stalled result holds the back end only at the frame's last pixel;
// input stalls only when the queue is full.
module uniform_border_margin_detect #(
    parameter int MAX_WIDTH  = ubmd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ubmd_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [23:0]                       s_tdata,   // pixel_color[23:0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // margin_left[11:0], margin_top[23:12], margin_right[35:24], margin_bottom[47:36]
    output logic [ubmd_pkg::RESULT_W-1:0]     m_tdata,
    input  logic                              cfg_we,
    input  logic [ubmd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ubmd_pkg::CFG_W-1:0]        cfg_wdata
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int CLR_W = ubmd_pkg::COLOR_W;
    localparam int QW = CLR_W + CW + RW + ubmd_pkg::FLAGS_W;

    logic [ubmd_pkg::CFG_W-1:0] frame_width_reg;
    logic [ubmd_pkg::CFG_W-1:0] frame_height_reg;
    logic                       cfg_clear;
    logic [WW-1:0]              w_eff;
    logic [HW-1:0]              h_eff;

    logic                 push, pop, q_full, head_valid;
    logic [CLR_W-1:0]     push_pixel, head_pixel;
    logic [CW-1:0]        push_col, head_col;
    logic [RW-1:0]        push_row, head_row;
    ubmd_pkg::pos_flags_t push_flags, head_flags;
    logic [QW-1:0]        head_data;

    assign cfg_clear = cfg_we && (cfg_index == ubmd_pkg::CFG_FRAME_WIDTH ||
                                  cfg_index == ubmd_pkg::CFG_FRAME_HEIGHT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= ubmd_pkg::RESET_FRAME_WIDTH;
            frame_height_reg <= ubmd_pkg::RESET_FRAME_HEIGHT;
        end else if (cfg_we) begin
            case (cfg_index)
                ubmd_pkg::CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata;
                ubmd_pkg::CFG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // zero acts as one, oversize clamps to the limit
    assign w_eff = (frame_width_reg == '0) ? WW'(1) :
                   (32'(frame_width_reg) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) :
                   WW'(frame_width_reg);
    assign h_eff = (frame_height_reg == '0) ? HW'(1) :
                   (32'(frame_height_reg) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) :
                   HW'(frame_height_reg);

    ubmd_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_clear  (cfg_clear),
        .w_eff      (w_eff),
        .h_eff      (h_eff),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_pixel    (s_tdata),
        .q_full     (q_full),
        .push       (push),
        .push_pixel (push_pixel),
        .push_col   (push_col),
        .push_row   (push_row),
        .push_flags (push_flags)
    );

    ubmd_queue #(
        .DATA_W (QW),
        .DEPTH  (ubmd_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  ({push_flags, push_row, push_col, push_pixel}),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    assign {head_flags, head_row, head_col, head_pixel} = head_data;

    ubmd_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_clear  (cfg_clear),
        .w_eff      (w_eff),
        .h_eff      (h_eff),
        .head_valid (head_valid),
        .head_pixel (head_pixel),
        .head_col   (head_col),
        .head_row   (head_row),
        .head_flags (head_flags),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

[bench/ubmd_margin_checker.sv]
`timescale 1ns / 1ps
module ubmd_margin_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [23:0]                    s_tdata,   // pixel_color[23:0]
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // margin_left[11:0], margin_top[23:12], margin_right[35:24], margin_bottom[47:36]
    input  logic [ubmd_pkg::RESULT_W-1:0]  m_tdata,
    input  logic                           cfg_we,
    input  logic [ubmd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ubmd_pkg::CFG_W-1:0]     cfg_wdata,
    output int unsigned                    mismatches,
    output int unsigned                    margins_pending,
    output int unsigned                    frames_checked
);
    import ubmd_pkg::*;

    // Packed so that margin_left lands in the lowest bits, as on m_tdata
    typedef struct packed {
        logic [MARGIN_W-1:0] bottom;
        logic [MARGIN_W-1:0] right;
        logic [MARGIN_W-1:0] top;
        logic [MARGIN_W-1:0] left;
    } margins_t;

    margins_t margins_due[$];

    logic [CFG_W-1:0]    width_reg;
    logic [CFG_W-1:0]    height_reg;

    logic [11:0]         col_pos;
    logic [11:0]         row_pos;
    logic [COLOR_W-1:0]  corner_tl;
    logic [11:0]         left_col;
    logic                left_hit;
    logic [11:0]         top_row;
    logic                top_hit;
    logic [COLOR_W-1:0]  last_px;
    logic [12:0]         lead_run;
    logic [COLOR_W-1:0]  corner_tr;
    logic [11:0]         right_col;
    logic                right_hit;
    logic [COLOR_W-1:0]  row_head;
    logic                row_flat;
    logic [12:0]         flat_rows;
    logic [COLOR_W-1:0]  flat_color;

    function automatic int unsigned fit_size(input logic [CFG_W-1:0] raw,
                                             input int unsigned limit);
        if (raw == '0)
            return 1;
        if (raw > limit)
            return limit;
        return 32'(raw);
    endfunction

    task automatic restart_frame();
        col_pos    = '0;
        row_pos    = '0;
        corner_tl  = '0;
        left_col   = '1;
        left_hit   = 1'b0;
        top_row    = '0;
        top_hit    = 1'b0;
        last_px    = '0;
        lead_run   = '0;
        corner_tr  = '0;
        right_col  = '0;
        right_hit  = 1'b0;
        row_head   = '0;
        row_flat   = 1'b1;
        flat_rows  = '0;
        flat_color = '0;
    endtask

    task automatic predict_pixel(input logic [COLOR_W-1:0] px);
        int unsigned w;
        int unsigned h;
        int unsigned col;
        int unsigned row;
        int unsigned span;
        logic        row_end;
        logic        frame_end;
        margins_t    due;
        w = fit_size(width_reg, DEF_MAX_WIDTH);
        h = fit_size(height_reg, DEF_MAX_HEIGHT);
        col = 32'(col_pos);
        row = 32'(row_pos);
        row_end = (col + 1 >= w);

        if (col == 0 && row == 0)
            corner_tl = px;

        if (px != corner_tl) begin
            if (!left_hit || col < left_col) begin
                left_col = col[11:0];
                left_hit = 1'b1;
            end
            if (!top_hit) begin
                top_row = row[11:0];
                top_hit = 1'b1;
            end
        end

        // Row 0 gives the right margin from its trailing run; later rows can push the right edge outward
        if (row == 0) begin
            if (col == 0 || px != last_px)
                lead_run = 13'd1;
            else
                lead_run = lead_run + 13'd1;
            last_px = px;
            if (row_end) begin
                corner_tr = px;
                if (lead_run < w) begin
                    right_col = 12'(w - 1 - lead_run);
                    right_hit = 1'b1;
                end
            end
        end else if (px != corner_tr) begin
            if (!right_hit || col > right_col) begin
                right_col = col[11:0];
                right_hit = 1'b1;
            end
        end

        if (col == 0) begin
            row_head = px;
            row_flat = 1'b1;
        end else if (px != row_head) begin
            row_flat = 1'b0;
        end
        if (row_end) begin
            if (!row_flat) begin
                flat_rows = '0;
            end else if (flat_rows > 0 && row_head == flat_color) begin
                flat_rows = flat_rows + 13'd1;
            end else begin
                flat_rows  = 13'd1;
                flat_color = row_head;
            end
        end

        frame_end = row_end && (row + 1 >= h);
        if (!frame_end) begin
            if (row_end) begin
                col_pos = '0;
                row_pos = 12'(row + 1);
            end else begin
                col_pos = 12'(col + 1);
            end
        end else begin
            span = w - 1 - right_col;
            due.left   = left_hit ? left_col : '0;
            due.top    = top_hit ? top_row : '0;
            due.right  = right_hit ? span[MARGIN_W-1:0] : '0;
            due.bottom = (flat_rows < h) ? flat_rows[MARGIN_W-1:0] : '0;
            margins_due.push_back(due);
            restart_frame();
        end
    endtask

    task automatic check_margins(input margins_t got);
        margins_t want;
        if (margins_due.size() == 0) begin
            $error("margins %h arrived with no frame outstanding", got);
            mismatches++;
        end else begin
            want = margins_due.pop_front();
            frames_checked++;
            if (got.left != want.left) begin
                $error("margin_left: expected %0d, actual %0d", want.left, got.left);
                mismatches++;
            end
            if (got.top != want.top) begin
                $error("margin_top: expected %0d, actual %0d", want.top, got.top);
                mismatches++;
            end
            if (got.right != want.right) begin
                $error("margin_right: expected %0d, actual %0d", want.right, got.right);
                mismatches++;
            end
            if (got.bottom != want.bottom) begin
                $error("margin_bottom: expected %0d, actual %0d", want.bottom, got.bottom);
                mismatches++;
            end
        end
    endtask

    initial begin
        mismatches      = 0;
        margins_pending = 0;
        frames_checked  = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  = RESET_FRAME_WIDTH;
            height_reg = RESET_FRAME_HEIGHT;
            restart_frame();
            margins_due.delete();
        end else begin
            if (m_tvalid && m_tready)
                check_margins(m_tdata);
            if (cfg_we) begin
                case (cfg_index)
                    CFG_FRAME_WIDTH:  width_reg = cfg_wdata;
                    CFG_FRAME_HEIGHT: height_reg = cfg_wdata;
                    default: ;
                endcase
                // Any register write drops the frame in progress
                restart_frame();
            end
            if (s_tvalid && s_tready)
                predict_pixel(s_tdata);
        end
        margins_pending = margins_due.size();
    end

endmodule

[bench/uniform_border_margin_detect_test.sv]
`timescale 1ns / 1ps
module uniform_border_margin_detect_test;
    import ubmd_pkg::*;

    localparam int          RESET_CYCLES  = 9;
    localparam int          DRAIN_CYCLES  = 8;
    localparam int          HOLD_CYCLES   = 300;
    localparam int unsigned RANDOM_PIXELS = 1800;
    localparam int unsigned MIN_FRAMES    = 48;
    localparam longint      LIMIT_NS      = 4_000_000;

    typedef enum int {
        FILL_FLAT,
        FILL_BOX,
        FILL_CORNERS,
        FILL_TWO_TONE,
        FILL_NOISE
    } fill_e;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [23:0]           s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [RESULT_W-1:0]   m_tdata;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_wdata;

    int unsigned           mismatches;
    int unsigned           margins_pending;
    int unsigned           frames_checked;

    logic                  s_accepted = 1'b0;
    logic                  tx_burst = 1'b0;
    logic                  rx_burst = 1'b0;
    logic                  rx_hold = 1'b0;

    int unsigned           frame_w;
    int unsigned           frame_h;
    int unsigned           pixels_sent = 0;
    int unsigned           reg_writes = 0;

    fill_e                 fill_mode;
    logic [COLOR_W-1:0]    bg_color;
    logic [COLOR_W-1:0]    fg_color;
    int unsigned           box_x0, box_x1, box_y0, box_y1;

    uniform_border_margin_detect u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    ubmd_margin_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .mismatches      (mismatches),
        .margins_pending (margins_pending),
        .frames_checked  (frames_checked)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Record each input transfer so the sender can look at it on the falling edge
    always @(posedge aclk) begin
        s_accepted <= s_tvalid && s_tready;
    end

    initial begin
        #(LIMIT_NS);
        $display("[uniform_border_margin_detect] ERROR");
        $finish;
    end

    function automatic int unsigned pick_tx_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 15);
        return $urandom_range(20, 40);
    endfunction

    function automatic int unsigned pick_rx_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [COLOR_W-1:0] pick_color();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return r[COLOR_W-1:0];
        endcase
    endfunction

    function automatic int unsigned fit_size(input int unsigned raw, input int unsigned limit);
        if (raw == 0)
            return 1;
        if (raw > limit)
            return limit;
        return raw;
    endfunction

    function automatic int unsigned pick_size();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 0;
        if (r < 3)
            return $urandom_range(9, 40);
        return $urandom_range(1, 8);
    endfunction

    function automatic logic [COLOR_W-1:0] frame_pixel(input int unsigned x, input int unsigned y);
        logic in_box;
        in_box = (x >= box_x0) && (x <= box_x1) && (y >= box_y0) && (y <= box_y1);
        case (fill_mode)
            FILL_FLAT:     return bg_color;
            FILL_BOX:      return !in_box ? bg_color :
                                  ($urandom_range(0, 1) ? fg_color : pick_color());
            FILL_CORNERS: begin
                if (x < box_x0 || y < box_y0)
                    return bg_color;
                if (x > box_x1 || y > box_y1)
                    return fg_color;
                case ($urandom_range(0, 2))
                    0:       return bg_color;
                    1:       return fg_color;
                    default: return pick_color();
                endcase
            end
            FILL_TWO_TONE: return ($urandom_range(0, 3) == 0) ? fg_color : bg_color;
            default:       return pick_color();
        endcase
    endfunction

    task automatic plan_frame();
        fill_mode = fill_e'($urandom_range(FILL_FLAT, FILL_NOISE));
        bg_color  = pick_color();
        fg_color  = pick_color();
        box_x0    = $urandom_range(0, frame_w - 1);
        box_x1    = $urandom_range(box_x0, frame_w - 1);
        box_y0    = $urandom_range(0, frame_h - 1);
        box_y1    = $urandom_range(box_y0, frame_h - 1);
    endtask

    // Called on a falling edge; returns on the falling edge after the transfer
    task automatic send_pixel(input logic [COLOR_W-1:0] px);
        int unsigned gap;
        gap = tx_burst ? 0 : pick_tx_gap();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = px;
        do @(negedge aclk); while (!s_accepted);
        pixels_sent++;
    endtask

    task automatic send_pixels(input int unsigned count);
        int unsigned n;
        for (n = 0; n < count; n++)
            send_pixel(frame_pixel(n % frame_w, n / frame_w));
    endtask

    // Hold the input until every frame is out and the pipeline has emptied
    task automatic drain();
        s_tvalid = 1'b0;
        while (margins_pending != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic configure(input logic [CFG_IDX_W-1:0] idx, input int unsigned raw);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = raw[CFG_W-1:0];
        @(negedge aclk);
        cfg_we    = 1'b0;
        if (idx == CFG_FRAME_WIDTH)
            frame_w = fit_size(raw, DEF_MAX_WIDTH);
        else
            frame_h = fit_size(raw, DEF_MAX_HEIGHT);
        reg_writes++;
    endtask

    // Output side: random back-pressure, plus one long hold-off on request
    initial begin : rx_side
        int unsigned gap;
        gap = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                rx_hold = 1'b0;
            end else if (gap > 0) begin
                m_tready = 1'b0;
                gap--;
            end else begin
                m_tready = 1'b1;
                if (!rx_burst && $urandom_range(0, 3) == 0)
                    gap = pick_rx_gap();
            end
        end
    end

    initial begin : stimulus
        int unsigned random_pixels;
        int unsigned phase;
        int unsigned nframes;
        int unsigned f;
        int unsigned new_w;
        int unsigned new_h;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_FRAME_WIDTH;
        cfg_wdata = '0;
        frame_w   = 32'(RESET_FRAME_WIDTH);
        frame_h   = 32'(RESET_FRAME_HEIGHT);
        random_pixels = 0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Zero register values: every pixel is a whole frame
        configure(CFG_FRAME_WIDTH, 0);
        configure(CFG_FRAME_HEIGHT, 0);
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        send_pixel(24'h5A5A5A);
        drain();

        // Abandon a frame part-way, then restart it with a register write
        configure(CFG_FRAME_WIDTH, 4);
        configure(CFG_FRAME_HEIGHT, 3);
        fill_mode = FILL_NOISE;
        send_pixels(5);
        drain();
        configure(CFG_FRAME_WIDTH, 3);
        send_pixel(24'h111111); send_pixel(24'h111111); send_pixel(24'h222222);
        send_pixel(24'h111111); send_pixel(24'h333333); send_pixel(24'h222222);
        send_pixel(24'h222222); send_pixel(24'h222222); send_pixel(24'h222222);
        drain();

        // Single column, then single row
        configure(CFG_FRAME_WIDTH, 1);
        configure(CFG_FRAME_HEIGHT, 4);
        send_pixel(24'hABCDEF); send_pixel(24'hABCDEF);
        send_pixel(24'h012345); send_pixel(24'h012345);
        drain();
        configure(CFG_FRAME_HEIGHT, 1);
        configure(CFG_FRAME_WIDTH, 5);
        send_pixel(24'h000000); send_pixel(24'h000000);
        send_pixel(24'hFFFFFF); send_pixel(24'hFFFFFF); send_pixel(24'hFFFFFF);
        drain();

        phase = 0;
        while (random_pixels < RANDOM_PIXELS || frames_checked < MIN_FRAMES) begin
            phase++;
            drain();
            tx_burst = ($urandom_range(0, 4) == 0);
            rx_burst = ($urandom_range(0, 4) == 0);
            if (phase == 3) begin
                // Stall the output while one-pixel frames keep coming in
                configure(CFG_FRAME_WIDTH, 1);
                configure(CFG_FRAME_HEIGHT, 1);
                fill_mode = FILL_NOISE;
                rx_hold = 1'b1;
                send_pixels(24);
                random_pixels += 24;
                continue;
            end
            new_w = pick_size();
            new_h = pick_size();
            if ($urandom_range(0, 1)) begin
                configure(CFG_FRAME_WIDTH, new_w);
                configure(CFG_FRAME_HEIGHT, new_h);
            end else begin
                configure(CFG_FRAME_HEIGHT, new_h);
                configure(CFG_FRAME_WIDTH, new_w);
            end
            nframes = $urandom_range(1, 4);
            for (f = 0; f < nframes; f++) begin
                plan_frame();
                send_pixels(frame_w * frame_h);
                random_pixels += frame_w * frame_h;
            end
            // Now and then leave a broken frame for the next write to discard
            if (frame_w * frame_h > 1 && $urandom_range(0, 5) == 0) begin
                plan_frame();
                nframes = $urandom_range(1, frame_w * frame_h - 1);
                send_pixels(nframes);
                random_pixels += nframes;
            end
        end

        drain();
        $display("Sent %0d pixels over %0d register writes; %0d frames of margins checked.",
                 pixels_sent, reg_writes, frames_checked);
        $display("Sizes ran from 1x1 to 40x40, with zero sizes, single rows and columns, a long output stall and a mid-frame restart.");
        if (mismatches == 0 && margins_pending == 0) begin
            $display("[uniform_border_margin_detect] OK");
        end else begin
            $display("[uniform_border_margin_detect] ERROR");
        end
        $finish;
    end

endmodule
